/* rtl/ddr_pkg.sv */
package ddr_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_W = 35;
  // Magnitude bits folded into the BCD word by one conversion stage.
  localparam int BITS_PER_STAGE = 4;

  typedef struct packed {
    logic valid;
    logic neg;
  } ddr_ctrl_t;

  // Decimal digits needed for the largest magnitude, 2^(w-1).
  function automatic int num_digits(input int w);
    longint unsigned m;
    longint unsigned p;
    int n;
    m = longint'(1) << (w - 1);
    p = 1;
    n = 0;
    while (p <= m) begin
      p = p * 10;
      n++;
    end
    return n;
  endfunction

  // Bits needed to hold any number of nd decimal digits.
  function automatic int rev_width(input int nd);
    longint unsigned p;
    int b;
    p = 1;
    b = 0;
    for (int i = 0; i < nd; i++) begin
      p = p * 10;
    end
    while ((longint'(1) << b) < p) begin
      b++;
    end
    return b;
  endfunction

endpackage

/* rtl/ddr_bcd_stage.sv */
module ddr_bcd_stage import ddr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int ND = num_digits(VALUE_WIDTH_DEF),
  parameter int BPS = BITS_PER_STAGE,
  parameter int IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ddr_ctrl_t              ctrl_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  input  logic [4*ND-1:0]        bcd_i,
  output ddr_ctrl_t              ctrl_o,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output logic [4*ND-1:0]        bcd_o
);

  localparam int NBS = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int PW = NBS * BPS;

  ddr_ctrl_t              ctrl_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [4*ND-1:0]        bcd_q, bcd_d;
  logic [PW-1:0]          mag_pad;
  logic [BPS-1:0]         chunk;

  assign mag_pad = PW'(mag_i);
  assign chunk = mag_pad[PW-1-IDX*BPS -: BPS];

  // Shift-add-3 conversion, most significant bit first.
  always_comb begin
    bcd_d = bcd_i;
    for (int b = BPS - 1; b >= 0; b--) begin
      for (int k = 0; k < ND; k++) begin
        if (bcd_d[4*k +: 4] >= 4'd5) begin
          bcd_d[4*k +: 4] = bcd_d[4*k +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[4*ND-2:0], chunk[b]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_i;
      bcd_q <= bcd_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign mag_o = mag_q;
  assign bcd_o = bcd_q;

endmodule

/* rtl/ddr_rev_stage.sv */
module ddr_rev_stage import ddr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int ND = num_digits(VALUE_WIDTH_DEF),
  parameter int RW = rev_width(num_digits(VALUE_WIDTH_DEF)),
  parameter int IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ddr_ctrl_t              ctrl_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  input  logic [4*ND-1:0]        bcd_i,
  input  logic [RW-1:0]          acc_i,
  output ddr_ctrl_t              ctrl_o,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output logic [4*ND-1:0]        bcd_o,
  output logic [RW-1:0]          acc_o
);

  ddr_ctrl_t              ctrl_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [4*ND-1:0]        bcd_q;
  logic [RW-1:0]          acc_q, acc_d;
  logic [3:0]             digit;
  logic                   upper_nz;

  assign digit = bcd_i[4*IDX +: 4];
  // A digit takes part only while it or some higher digit is nonzero, so the
  // unused leading digit positions of the BCD word never append zeros to the
  // result.
  assign upper_nz = |bcd_i[4*ND-1:4*IDX];
  assign acc_d = upper_nz ? (acc_i << 3) + (acc_i << 1) + RW'(digit) : acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_i;
      bcd_q <= bcd_i;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign mag_o = mag_q;
  assign bcd_o = bcd_q;
  assign acc_o = acc_q;

endmodule

/* rtl/decimal_digit_reverse_top.sv */
// Decimal digit reversal: each beat on the input carries a signed
// VALUE_WIDTH-bit integer, and the matching beat on the output carries the
// number formed by its decimal digits in reverse order with the sign kept
// (trailing zeros drop out), plus a flag that is set when the magnitude reads
// the same both ways. The most negative input is handled exactly. The
// pipeline takes one beat every cycle while the output is not stalled; in
// order it holds an input register, the binary-to-BCD stages (four bits per
// stage), the reassembly stages (one digit per stage) and an output
// register. A stalled output holds the whole pipeline.
module decimal_digit_reverse_top import ddr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] reversed_o,
  output logic                    is_palindrome_o
);

  localparam int ND = num_digits(VALUE_WIDTH);
  localparam int RW = rev_width(ND);
  localparam int NBS = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int XW = (RW > OUT_W) ? RW : OUT_W;

  logic en;

  ddr_ctrl_t              in_ctrl_q;
  logic [VALUE_WIDTH-1:0] in_mag_q;

  ddr_ctrl_t [NBS:0]                  b_ctrl;
  logic [NBS:0][VALUE_WIDTH-1:0]      b_mag;
  logic [NBS:0][4*ND-1:0]             b_bcd;

  ddr_ctrl_t [ND:0]                   r_ctrl;
  logic [ND:0][VALUE_WIDTH-1:0]       r_mag;
  logic [ND:0][4*ND-1:0]              r_bcd;
  logic [ND:0][RW-1:0]                r_acc;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] rev_q, rev_d;
  logic                    pal_q, pal_d;
  logic [XW-1:0]           acc_x, neg_x;

  // All stages move together; empty stages are filled whenever the output
  // register is free or being drained.
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctrl_q <= '0;
    end else if (en) begin
      in_ctrl_q.valid <= in_valid_i;
      in_ctrl_q.neg   <= value_i[VALUE_WIDTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_mag_q <= value_i[VALUE_WIDTH-1] ? -value_i : value_i;
    end
  end

  assign b_ctrl[0] = in_ctrl_q;
  assign b_mag[0] = in_mag_q;
  assign b_bcd[0] = '0;

  for (genvar s = 0; s < NBS; s++) begin : g_bcd
    ddr_bcd_stage #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .ND         (ND),
      .BPS        (BITS_PER_STAGE),
      .IDX        (s)
    ) u_bcd (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(b_ctrl[s]),
      .mag_i (b_mag[s]),
      .bcd_i (b_bcd[s]),
      .ctrl_o(b_ctrl[s+1]),
      .mag_o (b_mag[s+1]),
      .bcd_o (b_bcd[s+1])
    );
  end

  assign r_ctrl[0] = b_ctrl[NBS];
  assign r_mag[0] = b_mag[NBS];
  assign r_bcd[0] = b_bcd[NBS];
  assign r_acc[0] = '0;

  for (genvar d = 0; d < ND; d++) begin : g_rev
    ddr_rev_stage #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .ND         (ND),
      .RW         (RW),
      .IDX        (d)
    ) u_rev (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(r_ctrl[d]),
      .mag_i (r_mag[d]),
      .bcd_i (r_bcd[d]),
      .acc_i (r_acc[d]),
      .ctrl_o(r_ctrl[d+1]),
      .mag_o (r_mag[d+1]),
      .bcd_o (r_bcd[d+1]),
      .acc_o (r_acc[d+1])
    );
  end

  assign acc_x = XW'(r_acc[ND]);
  assign neg_x = -acc_x;
  assign rev_d = r_ctrl[ND].neg ? neg_x[OUT_W-1:0] : acc_x[OUT_W-1:0];
  assign pal_d = (RW'(r_mag[ND]) == r_acc[ND]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= r_ctrl[ND].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rev_q <= rev_d;
      pal_q <= pal_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reversed_o = rev_q;
  assign is_palindrome_o = pal_q;

endmodule

/* rtl/ddr_checker.sv */
module ddr_checker import ddr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic [VALUE_WIDTH-1:0]  value_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] reversed_o,
  input logic                    is_palindrome_o
);

  // A held output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(reversed_o) && $stable(is_palindrome_o))
    else $error("output beat changed while stalled");

  // Only a zero magnitude reverses to zero, and zero is a palindrome.
  a_zero_pal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reversed_o == '0) |-> is_palindrome_o)
    else $error("zero result without palindrome flag");

  // With the output register empty the pipeline must take input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output is empty");

  // A stalled output freezes the pipeline, so no beat may enter.
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");

endmodule

bind decimal_digit_reverse_top ddr_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_ddr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .value_i        (value_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .reversed_o     (reversed_o),
  .is_palindrome_o(is_palindrome_o)
);
